FILE: hdl/ptp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, widths, codes and helpers of the perceptron train/predict unit.
package ptp_pkg;

    localparam int MAX_LANES  = 8;
    localparam int FEAT_W     = 16;
    localparam int WGT_W      = 32;
    localparam int PROD_W     = FEAT_W + WGT_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int NET_W      = 40;
    localparam int RATE_W     = 16;
    localparam int CLASS_W    = 2;
    localparam int DIFF_W     = 3;
    localparam int DELTA_W    = RATE_W + DIFF_W;
    localparam int STEP_W     = DELTA_W + FEAT_W;
    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 112;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic        [OP_W-1:0]    opcode_t;
    typedef logic signed [FEAT_W-1:0]  feat_t;
    typedef logic signed [WGT_W-1:0]   wgt_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [STEP_W-1:0]  step_t;
    typedef logic signed [CLASS_W-1:0] class_t;

    localparam opcode_t OP_PREDICT = 2'd0;
    localparam opcode_t OP_TRAIN   = 2'd1;
    localparam opcode_t OP_CLEAR   = 2'd2;

    localparam class_t CLASS_POS  = 2'sb01;
    localparam class_t CLASS_NEG  = 2'sb11;
    localparam class_t CLASS_NONE = 2'sb00;

    typedef struct packed {
        logic clear;
        logic mul;
        logic sum1;
        logic sum2;
        logic net;
        logic step;
        logic upd;
        logic trk1;
        logic trk2;
    } ctl_t;

    function automatic wgt_t sat_wgt(input logic signed [WGT_W:0] v);
        wgt_t r;
        if (v[WGT_W] != v[WGT_W-1])
        begin
            r = v[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
        end
        else
        begin
            r = v[WGT_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ptp_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One feature lane: weight register, product multiplier and weight update.
module ptp_lane (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ptp_pkg::ctl_t ctl,
    input  wire ptp_pkg::feat_t  feature,
    input  wire ptp_pkg::delta_t delta,
    output ptp_pkg::prod_t     product,
    output ptp_pkg::wgt_t      weight
);

    ptp_pkg::wgt_t  weight_reg;
    ptp_pkg::wgt_t  weight_next;
    ptp_pkg::prod_t prod_reg;
    ptp_pkg::prod_t prod_next;
    ptp_pkg::step_t step_reg;
    ptp_pkg::step_t step_next;
    ptp_pkg::step_t step_rnd;

    always_comb
    begin
        prod_next   = feature * weight_reg;
        step_next   = delta * feature;
        step_rnd    = step_reg + ptp_pkg::step_t'(128);
        weight_next = ptp_pkg::sat_wgt(
            {weight_reg[ptp_pkg::WGT_W-1], weight_reg}
            + {{(ptp_pkg::WGT_W + 9 - ptp_pkg::STEP_W){step_rnd[ptp_pkg::STEP_W-1]}},
               step_rnd[ptp_pkg::STEP_W-1:8]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
        end
        else if (ctl.clear)
        begin
            weight_reg <= '0;
        end
        else if (ctl.upd)
        begin
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.step)
        begin
            step_reg <= step_next;
        end
    end

    assign product = prod_reg;
    assign weight  = weight_reg;

endmodule
`default_nettype wire

FILE: hdl/ptp_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// Merge stage: registered adder tree, rounding, saturation, class and delta.
module ptp_sum #(
    parameter int NUM_FEATURES = 8
) (
    input  wire logic                                    clk,
    input  wire ptp_pkg::ctl_t                           ctl,
    input  wire ptp_pkg::prod_t [NUM_FEATURES-1:0]       products,
    input  wire ptp_pkg::wgt_t                           bias,
    input  wire logic [ptp_pkg::RATE_W-1:0]              learning_rate,
    input  wire ptp_pkg::class_t                         target,
    output logic signed [ptp_pkg::NET_W-1:0]             net,
    output ptp_pkg::class_t                              pred,
    output ptp_pkg::delta_t                              delta
);

    localparam int PAIRS = ptp_pkg::MAX_LANES / 2;
    localparam int EXT_W = ptp_pkg::ACC_W - ptp_pkg::PROD_W;
    localparam int BEXT_W = ptp_pkg::ACC_W - ptp_pkg::WGT_W - 8;

    ptp_pkg::acc_t   prod_pad [ptp_pkg::MAX_LANES];
    ptp_pkg::acc_t   pair_reg [PAIRS];
    ptp_pkg::acc_t   bias_sc_reg;
    ptp_pkg::acc_t   acc_reg;
    ptp_pkg::acc_t   acc_rnd;
    logic            fits;
    logic            pos;
    logic signed [ptp_pkg::NET_W-1:0]  net_next;
    logic signed [ptp_pkg::NET_W-1:0]  net_reg;
    logic signed [ptp_pkg::DIFF_W-1:0] diff;
    ptp_pkg::class_t pred_next;
    ptp_pkg::class_t pred_reg;
    ptp_pkg::delta_t delta_next;
    ptp_pkg::delta_t delta_reg;

    for (genvar i = 0; i < ptp_pkg::MAX_LANES; i++)
    begin : g_pad
        if (i < NUM_FEATURES)
        begin : g_on
            assign prod_pad[i] = {{EXT_W{products[i][ptp_pkg::PROD_W-1]}}, products[i]};
        end
        else
        begin : g_off
            assign prod_pad[i] = '0;
        end
    end

    always_comb
    begin
        acc_rnd = (acc_reg + ptp_pkg::acc_t'(128)) >>> 8;
        fits = (&acc_rnd[ptp_pkg::ACC_W-1:ptp_pkg::NET_W-1])
            || !(|acc_rnd[ptp_pkg::ACC_W-1:ptp_pkg::NET_W-1]);
        if (fits)
        begin
            net_next = acc_rnd[ptp_pkg::NET_W-1:0];
        end
        else if (acc_rnd[ptp_pkg::ACC_W-1])
        begin
            net_next = {1'b1, {(ptp_pkg::NET_W-1){1'b0}}};
        end
        else
        begin
            net_next = {1'b0, {(ptp_pkg::NET_W-1){1'b1}}};
        end
        pos        = !net_next[ptp_pkg::NET_W-1] && (|net_next);
        pred_next  = pos ? ptp_pkg::CLASS_POS : ptp_pkg::CLASS_NEG;
        diff       = {target[ptp_pkg::CLASS_W-1], target} - (pos ? 3'sd1 : -3'sd1);
        delta_next = $signed({1'b0, learning_rate}) * diff;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum1)
        begin
            for (int k = 0; k < PAIRS; k++)
            begin
                pair_reg[k] <= prod_pad[2*k] + prod_pad[2*k+1];
            end
            bias_sc_reg <= {{BEXT_W{bias[ptp_pkg::WGT_W-1]}}, bias, 8'b0};
        end
        if (ctl.sum2)
        begin
            acc_reg <= (pair_reg[0] + pair_reg[1]) + (pair_reg[2] + pair_reg[3]) + bias_sc_reg;
        end
        if (ctl.net)
        begin
            net_reg   <= net_next;
            pred_reg  <= pred_next;
            delta_reg <= delta_next;
        end
    end

    assign net   = net_reg;
    assign pred  = pred_reg;
    assign delta = delta_reg;

endmodule
`default_nettype wire

FILE: hdl/ptp_track.sv
`timescale 1ns / 1ps
`default_nettype none
// Running min/max of the feature weights through a two-stage compare tree.
module ptp_track #(
    parameter int NUM_FEATURES = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ptp_pkg::ctl_t                     ctl,
    input  wire ptp_pkg::wgt_t [NUM_FEATURES-1:0]  weights,
    output ptp_pkg::wgt_t                          min_w,
    output ptp_pkg::wgt_t                          max_w
);

    localparam int PAIRS = ptp_pkg::MAX_LANES / 2;

    ptp_pkg::wgt_t lo_pad [ptp_pkg::MAX_LANES];
    ptp_pkg::wgt_t hi_pad [ptp_pkg::MAX_LANES];
    ptp_pkg::wgt_t lo1_reg [PAIRS];
    ptp_pkg::wgt_t hi1_reg [PAIRS];
    ptp_pkg::wgt_t min_reg;
    ptp_pkg::wgt_t min_next;
    ptp_pkg::wgt_t max_reg;
    ptp_pkg::wgt_t max_next;

    function automatic ptp_pkg::wgt_t smin(input ptp_pkg::wgt_t a, input ptp_pkg::wgt_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic ptp_pkg::wgt_t smax(input ptp_pkg::wgt_t a, input ptp_pkg::wgt_t b);
        return (a > b) ? a : b;
    endfunction

    for (genvar i = 0; i < ptp_pkg::MAX_LANES; i++)
    begin : g_pad
        if (i < NUM_FEATURES)
        begin : g_on
            assign lo_pad[i] = weights[i];
            assign hi_pad[i] = weights[i];
        end
        else
        begin : g_off
            assign lo_pad[i] = min_reg;
            assign hi_pad[i] = max_reg;
        end
    end

    always_comb
    begin
        min_next = smin(smin(smin(lo1_reg[0], lo1_reg[1]), smin(lo1_reg[2], lo1_reg[3])),
                        min_reg);
        max_next = smax(smax(smax(hi1_reg[0], hi1_reg[1]), smax(hi1_reg[2], hi1_reg[3])),
                        max_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.trk1)
        begin
            for (int k = 0; k < PAIRS; k++)
            begin
                lo1_reg[k] <= smin(lo_pad[2*k], lo_pad[2*k+1]);
                hi1_reg[k] <= smax(hi_pad[2*k], hi_pad[2*k+1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (ctl.clear)
        begin
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (ctl.trk2)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign min_w = min_reg;
    assign max_w = max_reg;

endmodule
`default_nettype wire

FILE: hdl/perceptron_train_predict_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the perceptron train/predict unit: sequencer, lanes, merge, trackers.
//
//  Port group   Role     Beat content
//  s_t*         in       one sample: opcode in tuser, features and target in tdata
//  m_t*         out      one result: class, net sum, weight min and max
//  p*           config   learning_rate at byte address 0
//
//  A clear beat goes from idle straight to the result step; a predict beat runs the
//  dependent chain of lane multiply, adder tree and rounding, and a train beat adds
//  delta step, lane update and min/max tree; no new input beat is taken before idle.
//  Reset zeroes all weights, the bias and both trackers and loads learning_rate 655.
//  s_tready is high only while the sequencer is idle; the result register may still
//  hold the previous beat then. A stalled m_tready holds the sequencer in its last step.
module perceptron_train_predict_unit #(
    parameter int NUM_FEATURES = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // feature_0..feature_7 (16 each), target_label (2), zero fill
    input  wire logic [ptp_pkg::IN_DATA_W-1:0]     s_tdata,
    // opcode (2)
    input  wire logic [ptp_pkg::OP_W-1:0]          s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // predicted_class (2), net_sum (40), min_weight (32), max_weight (32), zero fill
    output logic [ptp_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ptp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ptp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ptp_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam logic [ptp_pkg::RATE_W-1:0] RATE_RESET = 16'd655;
    localparam logic REG_RATE = 1'b0;
    localparam int TARGET_LSB = ptp_pkg::MAX_LANES * ptp_pkg::FEAT_W;
    localparam int OUT_PAD = ptp_pkg::OUT_DATA_W - ptp_pkg::CLASS_W - ptp_pkg::NET_W
                           - 2 * ptp_pkg::WGT_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MUL  = 10'b00_0000_0010,
        S_SUM1 = 10'b00_0000_0100,
        S_SUM2 = 10'b00_0000_1000,
        S_NET  = 10'b00_0001_0000,
        S_STEP = 10'b00_0010_0000,
        S_UPD  = 10'b00_0100_0000,
        S_TRK1 = 10'b00_1000_0000,
        S_TRK2 = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    ptp_pkg::ctl_t                        ctl;
    logic                                 accept;
    logic                                 load;
    logic                                 cfg_wr;
    logic [ptp_pkg::RATE_W-1:0]           rate_reg;
    ptp_pkg::wgt_t                        bias_reg;
    ptp_pkg::wgt_t                        bias_next;
    ptp_pkg::opcode_t                     op_reg;
    ptp_pkg::feat_t                       feat_reg [NUM_FEATURES];
    ptp_pkg::class_t                      target_reg;
    ptp_pkg::prod_t [NUM_FEATURES-1:0]    products;
    ptp_pkg::wgt_t  [NUM_FEATURES-1:0]    weights;
    logic signed [ptp_pkg::NET_W-1:0]     net;
    logic signed [ptp_pkg::NET_W-1:0]     net_out;
    ptp_pkg::class_t                      pred;
    ptp_pkg::class_t                      pred_out;
    ptp_pkg::delta_t                      delta;
    ptp_pkg::wgt_t                        min_w;
    ptp_pkg::wgt_t                        max_w;
    logic                                 m_valid_reg;
    logic [ptp_pkg::OUT_DATA_W-1:0]       m_data_reg;
    logic [ptp_pkg::OUT_DATA_W-1:0]       m_data_next;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    always_comb
    begin
        ctl.clear = accept && (s_tuser == ptp_pkg::OP_CLEAR);
        ctl.mul   = (state_reg == S_MUL);
        ctl.sum1  = (state_reg == S_SUM1);
        ctl.sum2  = (state_reg == S_SUM2);
        ctl.net   = (state_reg == S_NET);
        ctl.step  = (state_reg == S_STEP);
        ctl.upd   = (state_reg == S_UPD);
        ctl.trk1  = (state_reg == S_TRK1);
        ctl.trk2  = (state_reg == S_TRK2);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser == ptp_pkg::OP_CLEAR) ? S_DONE : S_MUL;
                end
            end
            S_MUL:  state_next = S_SUM1;
            S_SUM1: state_next = S_SUM2;
            S_SUM2: state_next = S_NET;
            S_NET:  state_next = (op_reg == ptp_pkg::OP_TRAIN) ? S_STEP : S_DONE;
            S_STEP: state_next = S_UPD;
            S_UPD:  state_next = S_TRK1;
            S_TRK1: state_next = S_TRK2;
            S_TRK2: state_next = S_DONE;
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            target_reg <= s_tdata[TARGET_LSB +: ptp_pkg::CLASS_W];
            for (int i = 0; i < NUM_FEATURES; i++)
            begin
                feat_reg[i] <= s_tdata[i*ptp_pkg::FEAT_W +: ptp_pkg::FEAT_W];
            end
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RATE)
                  ? {{(ptp_pkg::APB_DATA_W - ptp_pkg::RATE_W){1'b0}}, rate_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_RATE))
        begin
            rate_reg <= pwdata[ptp_pkg::RATE_W-1:0];
        end
    end

    assign bias_next = ptp_pkg::sat_wgt(
        {bias_reg[ptp_pkg::WGT_W-1], bias_reg}
        + {{(ptp_pkg::WGT_W + 1 - ptp_pkg::DELTA_W){delta[ptp_pkg::DELTA_W-1]}}, delta});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (ctl.clear)
        begin
            bias_reg <= '0;
        end
        else if (ctl.upd)
        begin
            bias_reg <= bias_next;
        end
    end

    for (genvar i = 0; i < NUM_FEATURES; i++)
    begin : g_lane
        ptp_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .feature (feat_reg[i]),
            .delta   (delta),
            .product (products[i]),
            .weight  (weights[i])
        );
    end

    ptp_sum #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_sum (
        .clk           (clk),
        .ctl           (ctl),
        .products      (products),
        .bias          (bias_reg),
        .learning_rate (rate_reg),
        .target        (target_reg),
        .net           (net),
        .pred          (pred),
        .delta         (delta)
    );

    ptp_track #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .weights (weights),
        .min_w   (min_w),
        .max_w   (max_w)
    );

    always_comb
    begin
        if (op_reg == ptp_pkg::OP_CLEAR)
        begin
            pred_out = ptp_pkg::CLASS_NONE;
            net_out  = '0;
        end
        else
        begin
            pred_out = pred;
            net_out  = net;
        end
        m_data_next = {{OUT_PAD{1'b0}}, max_w, min_w, net_out, pred_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (bias_reg == '0) && (min_w == '0) && (max_w == '0))
        else $error("clear beat left state nonzero");

    a_track_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (min_w <= 0) && (max_w >= 0))
        else $error("weight trackers lost zero from their range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the final step");

    a_bias_update_only: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(bias_reg) |-> $past(ctl.upd || ctl.clear))
        else $error("bias changed outside update or clear");

endmodule
`default_nettype wire

FILE: sim/ptp_outcome_checker.sv
`timescale 1ns / 1ps
// Checker for the perceptron unit: mirrors weights from accepted beats and checks each result.
module ptp_outcome_checker #(
    parameter int                             NUM_FEATURES = 8,
    parameter logic [ptp_pkg::APB_ADDR_W-1:0] RATE_ADDR    = '0
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [ptp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [ptp_pkg::OP_W-1:0]       s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [ptp_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ptp_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic                           pready,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int     LABEL_LSB  = ptp_pkg::MAX_LANES * ptp_pkg::FEAT_W;
    localparam int     NET_LSB    = ptp_pkg::CLASS_W;
    localparam int     LO_LSB     = NET_LSB + ptp_pkg::NET_W;
    localparam int     HI_LSB     = LO_LSB + ptp_pkg::WGT_W;
    localparam int     REPORT_MAX = 10;
    localparam logic [ptp_pkg::RATE_W-1:0] RATE_RESET = 16'd655;
    localparam longint NET_HI = (longint'(1) <<< (ptp_pkg::NET_W - 1)) - 1;
    localparam longint NET_LO = -(longint'(1) <<< (ptp_pkg::NET_W - 1));
    localparam longint WGT_HI = (longint'(1) <<< (ptp_pkg::WGT_W - 1)) - 1;
    localparam longint WGT_LO = -(longint'(1) <<< (ptp_pkg::WGT_W - 1));

    typedef struct packed {
        ptp_pkg::class_t                  cls;
        logic signed [ptp_pkg::NET_W-1:0] net;
        ptp_pkg::wgt_t                    lo;
        ptp_pkg::wgt_t                    hi;
    } outcome_t;

    ptp_pkg::wgt_t              weights [ptp_pkg::MAX_LANES];
    ptp_pkg::wgt_t              bias;
    ptp_pkg::wgt_t              lowest;
    ptp_pkg::wgt_t              highest;
    logic [ptp_pkg::RATE_W-1:0] rate;
    outcome_t                   expected_q [$];
    int                         errors;

    function automatic longint round_q16(longint v);
        return (v + 128) >>> 8;
    endfunction

    function automatic ptp_pkg::wgt_t clamp_weight(longint v);
        if (v > WGT_HI)
        begin
            return ptp_pkg::wgt_t'(WGT_HI);
        end
        if (v < WGT_LO)
        begin
            return ptp_pkg::wgt_t'(WGT_LO);
        end
        return ptp_pkg::wgt_t'(v);
    endfunction

    function automatic outcome_t score_sample(ptp_pkg::opcode_t op,
                                              logic [ptp_pkg::IN_DATA_W-1:0] beat);
        outcome_t       r;
        ptp_pkg::feat_t f;
        longint         acc;
        longint         net;
        longint         sign;
        longint         delta;
        longint         target;
        r = '0;
        if (op == ptp_pkg::OP_CLEAR)
        begin
            for (int i = 0; i < ptp_pkg::MAX_LANES; i++)
            begin
                weights[i] = '0;
            end
            bias    = '0;
            lowest  = '0;
            highest = '0;
            return r;
        end
        acc = longint'(bias) * 256;
        for (int i = 0; i < NUM_FEATURES && i < ptp_pkg::MAX_LANES; i++)
        begin
            f = beat[i*ptp_pkg::FEAT_W +: ptp_pkg::FEAT_W];
            acc += longint'(f) * longint'(weights[i]);
        end
        net = round_q16(acc);
        if (net > NET_HI)
        begin
            net = NET_HI;
        end
        else if (net < NET_LO)
        begin
            net = NET_LO;
        end
        sign = (net > 0) ? 1 : -1;
        if (op == ptp_pkg::OP_TRAIN)
        begin
            target = longint'($signed(beat[LABEL_LSB +: ptp_pkg::CLASS_W]));
            delta  = longint'(rate) * (target - sign);
            for (int i = 0; i < NUM_FEATURES && i < ptp_pkg::MAX_LANES; i++)
            begin
                f = beat[i*ptp_pkg::FEAT_W +: ptp_pkg::FEAT_W];
                weights[i] = clamp_weight(longint'(weights[i]) + round_q16(delta * longint'(f)));
                if (weights[i] < lowest)
                begin
                    lowest = weights[i];
                end
                if (weights[i] > highest)
                begin
                    highest = weights[i];
                end
            end
            bias = clamp_weight(longint'(bias) + delta);
        end
        r.cls = (sign > 0) ? ptp_pkg::CLASS_POS : ptp_pkg::CLASS_NEG;
        r.net = net[ptp_pkg::NET_W-1:0];
        r.lo  = lowest;
        r.hi  = highest;
        return r;
    endfunction

    task automatic note_failure(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= REPORT_MAX)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t seen;
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ptp_pkg::MAX_LANES; i++)
            begin
                weights[i] = '0;
            end
            bias    = '0;
            lowest  = '0;
            highest = '0;
            rate    = RATE_RESET;
            errors  = 0;
            expected_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == RATE_ADDR)
            begin
                rate = pwdata[ptp_pkg::RATE_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                seen.cls = m_tdata[0 +: ptp_pkg::CLASS_W];
                seen.net = m_tdata[NET_LSB +: ptp_pkg::NET_W];
                seen.lo  = m_tdata[LO_LSB +: ptp_pkg::WGT_W];
                seen.hi  = m_tdata[HI_LSB +: ptp_pkg::WGT_W];
                if (expected_q.size() == 0)
                begin
                    note_failure("unrequested result beat", '0, 64'(m_tdata));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (seen.cls !== want.cls)
                    begin
                        note_failure("predicted_class", 64'(want.cls), 64'(seen.cls));
                    end
                    if (seen.net !== want.net)
                    begin
                        note_failure("net_sum", 64'(want.net), 64'(seen.net));
                    end
                    if (seen.lo !== want.lo)
                    begin
                        note_failure("min_weight", 64'(want.lo), 64'(seen.lo));
                    end
                    if (seen.hi !== want.hi)
                    begin
                        note_failure("max_weight", 64'(want.hi), 64'(seen.hi));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_q.insert(expected_q.size(), score_sample(s_tuser, s_tdata));
            end
            mismatches  <= errors;
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: sim/tb_perceptron_train_predict_unit.sv
`timescale 1ns / 1ps
// Testbench top for the perceptron unit: clock, reset, APB writes, sample beats, stalls, verdict.
module tb_perceptron_train_predict_unit;

    localparam ptp_pkg::opcode_t               OP_SPARE        = 2'd3;
    localparam logic [ptp_pkg::APB_ADDR_W-1:0] ADDR_RATE       = 3'd0;
    localparam logic [ptp_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;
    localparam ptp_pkg::class_t                TARGET_LOW      = 2'sb10;
    localparam ptp_pkg::feat_t                 FEAT_MAX        = 16'sh7FFF;
    localparam ptp_pkg::feat_t                 FEAT_MIN        = 16'sh8000;
    localparam int                             FEATS_W         = ptp_pkg::MAX_LANES
                                                               * ptp_pkg::FEAT_W;
    localparam int                             LABEL_LSB       = FEATS_W;
    localparam int                             FILL_W          = ptp_pkg::IN_DATA_W - LABEL_LSB
                                                               - ptp_pkg::CLASS_W;
    localparam int                             HALF            = ptp_pkg::MAX_LANES / 2;
    localparam int                             IDLE_LIMIT      = 3000;
    localparam int                             SETTLE_CYCLES   = 12;
    localparam int                             HOLD_OFF_CYCLES = 400;
    localparam int                             HOLD_OFF_AFTER  = 150;

    localparam logic [FEATS_W-1:0] SPLIT_UP   = {{HALF{FEAT_MIN}}, {HALF{FEAT_MAX}}};
    localparam logic [FEATS_W-1:0] SPLIT_DOWN = {{HALF{FEAT_MAX}}, {HALF{FEAT_MIN}}};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    // feature_0..feature_7 (16 each), target_label (2), zero fill
    logic [ptp_pkg::IN_DATA_W-1:0]  s_tdata;
    // opcode (2)
    logic [ptp_pkg::OP_W-1:0]       s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    // predicted_class (2), net_sum (40), min_weight (32), max_weight (32), zero fill
    logic [ptp_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ptp_pkg::APB_ADDR_W-1:0] paddr;
    logic [ptp_pkg::APB_DATA_W-1:0] pwdata;
    logic [ptp_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    int                             mismatches;
    int                             outstanding;
    int                             idle_cycles = 0;
    int                             results_seen = 0;
    int                             steady_left = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    perceptron_train_predict_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ptp_outcome_checker #(
        .RATE_ADDR (ADDR_RATE)
    ) outcome_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
            end
        end
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        if (r < 3)
        begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic ptp_pkg::feat_t random_feature();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return FEAT_MAX;
        end
        if (r < 20)
        begin
            return FEAT_MIN;
        end
        if (r < 35)
        begin
            return ptp_pkg::feat_t'($urandom_range(0, 1023)) - ptp_pkg::feat_t'(512);
        end
        if (r < 40)
        begin
            return '0;
        end
        return ptp_pkg::feat_t'($urandom_range(0, 65535));
    endfunction

    function automatic ptp_pkg::class_t random_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return ptp_pkg::CLASS_POS;
        end
        if (r < 80)
        begin
            return ptp_pkg::CLASS_NEG;
        end
        if (r < 90)
        begin
            return ptp_pkg::CLASS_NONE;
        end
        return TARGET_LOW;
    endfunction

    function automatic ptp_pkg::opcode_t random_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 52)
        begin
            return ptp_pkg::OP_TRAIN;
        end
        if (r < 84)
        begin
            return ptp_pkg::OP_PREDICT;
        end
        if (r < 96)
        begin
            return OP_SPARE;
        end
        return ptp_pkg::OP_CLEAR;
    endfunction

    function automatic logic [FEATS_W-1:0] lanes(ptp_pkg::feat_t v);
        return {ptp_pkg::MAX_LANES{v}};
    endfunction

    task automatic send_beat(ptp_pkg::opcode_t op, logic [FEATS_W-1:0] feats,
                             ptp_pkg::class_t target);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{FILL_W{1'b0}}, target, feats};
        do @(posedge clk); while (!s_tready);
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_random(int count);
        logic [FEATS_W-1:0] feats;
        for (int k = 0; k < count; k++)
        begin
            for (int i = 0; i < ptp_pkg::MAX_LANES; i++)
            begin
                feats[i*ptp_pkg::FEAT_W +: ptp_pkg::FEAT_W] = random_feature();
            end
            send_beat(random_opcode(), feats, random_target());
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [ptp_pkg::APB_ADDR_W-1:0] addr,
                             logic [ptp_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int  r;
        int  stretch;
        bit  steady;
        bit  held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            steady  = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(20, 200);
            repeat (stretch)
            begin
                @(posedge clk);
                if (!held && results_seen >= HOLD_OFF_AFTER)
                begin
                    held = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                r = $urandom_range(0, 99);
                if (steady || r >= 30)
                begin
                    m_tready <= 1'b1;
                end
                else if (r < 2)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
                else
                begin
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ptp_pkg::OP_PREDICT;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= ADDR_RATE;
        pwdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(ptp_pkg::OP_PREDICT, lanes('0), ptp_pkg::CLASS_POS);
        send_beat(OP_SPARE, lanes(FEAT_MAX), ptp_pkg::CLASS_NEG);
        send_beat(ptp_pkg::OP_TRAIN, lanes(FEAT_MAX), ptp_pkg::CLASS_POS);
        send_beat(ptp_pkg::OP_TRAIN, lanes(FEAT_MIN), ptp_pkg::CLASS_POS);
        send_beat(ptp_pkg::OP_PREDICT, lanes(FEAT_MAX), ptp_pkg::CLASS_NEG);
        send_beat(ptp_pkg::OP_PREDICT, lanes(FEAT_MIN), ptp_pkg::CLASS_NEG);
        send_beat(ptp_pkg::OP_TRAIN, SPLIT_UP, ptp_pkg::CLASS_NONE);
        send_beat(ptp_pkg::OP_TRAIN, SPLIT_DOWN, TARGET_LOW);
        send_beat(ptp_pkg::OP_TRAIN, lanes(16'sh0001), ptp_pkg::CLASS_NEG);
        send_beat(ptp_pkg::OP_TRAIN, lanes(16'shFFFF), ptp_pkg::CLASS_POS);
        send_beat(ptp_pkg::OP_TRAIN, lanes(16'sh0080), TARGET_LOW);
        send_beat(ptp_pkg::OP_TRAIN, lanes('0), ptp_pkg::CLASS_POS);
        send_beat(ptp_pkg::OP_PREDICT, lanes('0), ptp_pkg::CLASS_POS);
        send_beat(ptp_pkg::OP_CLEAR, lanes(FEAT_MAX), ptp_pkg::CLASS_POS);
        send_beat(ptp_pkg::OP_PREDICT, lanes(FEAT_MAX), ptp_pkg::CLASS_POS);
        send_beat(ptp_pkg::OP_TRAIN, {HALF{16'sh5555, 16'shAAAA}}, ptp_pkg::CLASS_NEG);
        send_beat(ptp_pkg::OP_CLEAR, lanes('0), ptp_pkg::CLASS_NEG);
        send_beat(OP_SPARE, lanes(FEAT_MIN), ptp_pkg::CLASS_POS);
        settle();

        // drive opposite lane halves to both weight rails at full rate
        write_reg(ADDR_RATE, {16'($urandom_range(0, 65535)), 16'hFFFF});
        send_beat(ptp_pkg::OP_CLEAR, lanes('0), ptp_pkg::CLASS_POS);
        repeat (264) send_beat(ptp_pkg::OP_TRAIN, SPLIT_UP, TARGET_LOW);
        repeat (8) send_beat(ptp_pkg::OP_PREDICT, SPLIT_DOWN, ptp_pkg::CLASS_POS);
        repeat (4) send_beat(ptp_pkg::OP_PREDICT, SPLIT_UP, ptp_pkg::CLASS_POS);
        run_random(170);
        settle();

        write_reg(ADDR_UNMAPPED, $urandom);
        write_reg(ADDR_RATE, {16'($urandom_range(0, 65535)), 16'h0000});
        run_random(120);
        settle();

        write_reg(ADDR_RATE, 32'd1);
        run_random(120);
        settle();

        write_reg(ADDR_RATE, $urandom);
        send_beat(ptp_pkg::OP_CLEAR, lanes('0), ptp_pkg::CLASS_POS);
        run_random(260);
        settle();

        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
